/* hdl/iamh_pkg.sv */
// Package for the integer ALU core: operation and status codes, payload types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package iamh_pkg;
  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_MUL = 3'd1,
    OP_MOD = 3'd2,
    OP_HYP = 3'd3
  } op_code_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_OP   = 2'd1,
    ST_DIV_ZERO = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } req_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
  } rsp_t;

  // Pipeline depth: magnitude/square stage, 32 combined divide and root steps, output.
  localparam int unsigned Steps = 32;
  localparam int unsigned Depth = Steps + 2;
endpackage
`default_nettype wire

/* hdl/integer_alu_add_mul_mod_hypot_core.sv */
// Integer ALU core: add, multiply, truncating modulo and integer hypotenuse.
// The pipe has 34 register stages and accepts one item per cycle while the output
// is not stalled.
// Each step stage runs one restoring-divide step and one square-root step in parallel.
// A stall freezes every stage at once, so items keep their order and none are lost.
// Reset clears all stage valid bits; the data registers are not reset.
// Depends on iamh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module integer_alu_add_mul_mod_hypot_core import iamh_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire req_t in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output rsp_t      out_data
);
  typedef struct packed {
    logic [2:0]  op;
    logic        neg_a;
    logic        zero_b;
    logic [31:0] simple;   // add or multiply result
    logic [31:0] dq;       // dividend bits shifted out as the divide runs
    logic [31:0] dd;       // divisor magnitude
    logic [32:0] drem;     // partial remainder
    logic [63:0] rn;       // radicand, consumed two bits a step
    logic [33:0] rrem;     // partial root remainder
    logic [31:0] root;
  } stage_t;

  stage_t      st [Depth-1];
  logic [Depth-2:0] vld;
  logic        adv;
  logic [31:0] mag_a, mag_b;
  logic [63:0] sq_a, sq_b;

  // The whole pipe moves unless the output holds an item that is stalled.
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  assign mag_a = in_data.operand_a[31] ? 32'(-in_data.operand_a) : in_data.operand_a;
  assign mag_b = in_data.operand_b[31] ? 32'(-in_data.operand_b) : in_data.operand_b;

  // Stage 0 forms the squares; the sum follows in stage 1.
  logic [63:0] sqa_r, sqb_r;
  assign sq_a = mag_a * mag_a;
  assign sq_b = mag_b * mag_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Depth-3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0].op     <= in_data.operation;
      st[0].neg_a  <= in_data.operand_a[31];
      st[0].zero_b <= (in_data.operand_b == 32'sd0);
      st[0].simple <= (in_data.operation == OP_ADD) ?
                      32'(in_data.operand_a + in_data.operand_b) :
                      32'(in_data.operand_a * in_data.operand_b);
      st[0].dq     <= mag_a;
      st[0].dd     <= mag_b;
      st[0].drem   <= '0;
      st[0].rn     <= '0;
      st[0].rrem   <= '0;
      st[0].root   <= '0;
      sqa_r        <= sq_a;
      sqb_r        <= sq_b;
    end
  end

  // Iterative steps: stage k+1 does divide step k and root step k.
  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic [32:0] dtrial;
    logic [33:0] rsh, rtry;
    logic [63:0] rn_in;
    stage_t      cur;
    stage_t      step_next;
    always_comb begin
      cur    = st[k];
      rn_in  = (k == 0) ? (sqa_r + sqb_r) : cur.rn;
      dtrial = {cur.drem[31:0], cur.dq[31]};
      rsh    = {cur.rrem[31:0], rn_in[63:62]};
      rtry   = {cur.root, 2'b01};
      step_next      = cur;
      step_next.dq   = {cur.dq[30:0], 1'b0};
      step_next.drem = (dtrial >= {1'b0, cur.dd}) ? 33'(dtrial - {1'b0, cur.dd}) : dtrial;
      step_next.rn   = {rn_in[61:0], 2'b00};
      if (rsh >= rtry) begin
        step_next.rrem = 34'(rsh - rtry);
        step_next.root = {cur.root[30:0], 1'b1};
      end else begin
        step_next.rrem = rsh;
        step_next.root = {cur.root[30:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        st[k+1] <= step_next;
      end
    end
  end

  // Output register: select the result by operation.
  stage_t      fin;
  logic [31:0] rem_s;
  rsp_t        rsp_next;
  assign fin   = st[Steps];
  assign rem_s = fin.neg_a ? 32'(-fin.drem[31:0]) : fin.drem[31:0];

  always_comb begin
    rsp_next = '{value: '0, status: ST_OK};
    unique case (fin.op)
      OP_ADD, OP_MUL: rsp_next.value = fin.simple;
      OP_MOD: begin
        if (fin.zero_b) rsp_next.status = ST_DIV_ZERO;
        else            rsp_next.value  = rem_s;
      end
      OP_HYP: rsp_next.value = fin.root[31] ? 32'h7FFF_FFFF : fin.root;
      default: rsp_next.status = ST_BAD_OP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[Depth-2];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= rsp_next;
    end
  end
endmodule
`default_nettype wire

/* hdl/iamh_checker.sv */
// Port-level checker for the integer ALU core, bound into the core module.
// Depends on iamh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module iamh_checker import iamh_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire rsp_t out_data
);
  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Input is held off exactly when a result is stalled.
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output stall");

  // A stalled request stays offered.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid)
    else $error("stalled request withdrawn");

  // An error status always comes with a zero value.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_OK |-> out_data.value == 32'sd0)
    else $error("nonzero value with error status");

  // Status is never the unused code.
  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status != 2'd3)
    else $error("undefined status code");
endmodule

bind integer_alu_add_mul_mod_hypot_core iamh_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire
